// File: rtl/core/bmp_pkg.sv
// Shared types, constants and helper functions for the BLE MIDI packet parser.
// Used by the front end, the job queue, the back end and the top level.
package bmp_pkg;

    // Default depth of the job queue between the front and back ends.
    localparam int QUEUE_DEPTH_DEF = 4;

    // MIDI status bytes and masks that the parser looks at.
    localparam logic [7:0] ST_SYSEX_START = 8'hF0;
    localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
    localparam logic [7:0] ST_PROG_CHANGE = 8'hC0;
    localparam logic [7:0] ST_CHAN_PRESS  = 8'hD0;
    localparam logic [7:0] ST_MTC_QFRAME  = 8'hF1;
    localparam logic [7:0] ST_SONG_POS    = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL    = 8'hF3;
    localparam logic [7:0] ST_STATUS_BIT  = 8'h80;
    localparam logic [7:0] ST_HI_MASK     = 8'hF0;

    // One job: up to three message bytes that one input byte releases.
    // first applies to bytes[0], last applies to bytes[cnt-1].
    typedef struct packed {
        logic [1:0]      cnt;
        logic            first;
        logic            last;
        logic [2:0][7:0] bytes;
    } t_job;

    // Total size of a message in bytes, judged by its status byte.
    // Zero for a data byte and for the sysex start.
    function automatic logic [1:0] msg_size(input logic [7:0] st);
        logic [1:0] sz;
        logic [7:0] hi;
        hi = st & ST_HI_MASK;
        if ((st & ST_STATUS_BIT) == 8'h00) begin
            sz = 2'd0;
        end else if (hi != ST_HI_MASK) begin
            sz = (hi == ST_PROG_CHANGE || hi == ST_CHAN_PRESS) ? 2'd2 : 2'd3;
        end else if (st == ST_SYSEX_START) begin
            sz = 2'd0;
        end else if (st == ST_MTC_QFRAME || st == ST_SONG_SEL) begin
            sz = 2'd2;
        end else if (st == ST_SONG_POS) begin
            sz = 2'd3;
        end else begin
            sz = 2'd1;
        end
        return sz;
    endfunction

endpackage

// File: rtl/core/bmp_front.sv
// Front end of the BLE MIDI packet parser: walks the packet phases and turns
// each accepted byte into at most one job. Depends on bmp_pkg.
module bmp_front
    import bmp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    output logic       o_push,
    output t_job       o_job
);

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_STAMP   = 3'd1;
    localparam logic [2:0] PH_STATUS  = 3'd2;
    localparam logic [2:0] PH_COLLECT = 3'd3;
    localparam logic [2:0] PH_SYSEX   = 3'd4;

    logic [2:0] r_phase, n_phase;
    logic [7:0] r_status, n_status;
    logic [7:0] r_data, n_data;
    logic [1:0] r_pend, n_pend;
    logic       emit;
    logic [1:0] sz_in;

    assign sz_in = msg_size(i_byte);

    always_comb begin
        n_phase  = PH_STAMP;
        n_status = r_status;
        n_data   = r_data;
        n_pend   = r_pend;
        emit     = 1'b0;
        o_job    = '0;
        case (r_phase)
            PH_STAMP: begin
                n_phase = PH_STATUS;
            end
            PH_STATUS: begin
                if ((i_byte & ST_STATUS_BIT) == 8'h00) begin
                    n_phase = PH_STAMP;
                end else if (i_byte == ST_SYSEX_START) begin
                    emit           = 1'b1;
                    o_job.cnt      = 2'd1;
                    o_job.first    = 1'b1;
                    o_job.last     = i_end;
                    o_job.bytes[0] = i_byte;
                    n_phase        = PH_SYSEX;
                end else if (sz_in == 2'd1) begin
                    emit           = 1'b1;
                    o_job.cnt      = 2'd1;
                    o_job.first    = 1'b1;
                    o_job.last     = 1'b1;
                    o_job.bytes[0] = i_byte;
                    n_phase        = PH_STAMP;
                end else begin
                    n_status = i_byte;
                    n_pend   = sz_in - 2'd1;
                    n_phase  = PH_COLLECT;
                end
            end
            PH_COLLECT: begin
                if (r_pend == 2'd2) begin
                    n_data  = i_byte;
                    n_pend  = 2'd1;
                    n_phase = PH_COLLECT;
                end else begin
                    emit           = 1'b1;
                    o_job.first    = 1'b1;
                    o_job.last     = 1'b1;
                    o_job.bytes[0] = r_status;
                    if (msg_size(r_status) == 2'd3) begin
                        o_job.cnt      = 2'd3;
                        o_job.bytes[1] = r_data;
                        o_job.bytes[2] = i_byte;
                    end else begin
                        o_job.cnt      = 2'd2;
                        o_job.bytes[1] = i_byte;
                    end
                    n_pend  = 2'd0;
                    n_phase = PH_STAMP;
                end
            end
            PH_SYSEX: begin
                emit           = 1'b1;
                o_job.cnt      = 2'd1;
                o_job.first    = 1'b0;
                o_job.bytes[0] = i_byte;
                if (i_byte == ST_SYSEX_END) begin
                    o_job.last = 1'b1;
                    n_phase    = PH_STAMP;
                end else begin
                    o_job.last = i_end;
                    n_phase    = PH_SYSEX;
                end
            end
            default: begin
                n_phase = PH_STAMP;
            end
        endcase
        if (i_end) begin
            n_phase = PH_HEADER;
            n_pend  = 2'd0;
        end
    end

    assign o_push = i_accept & emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_status <= '0;
            r_data   <= '0;
            r_pend   <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_status <= n_status;
            r_data   <= n_data;
            r_pend   <= n_pend;
        end
    end

endmodule

// File: rtl/core/bmp_fifo.sv
// Short job queue between the front and back ends of the packet parser.
// Depends on bmp_pkg for the job type.
module bmp_fifo
    import bmp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_wr_job,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_job o_rd_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_valid  = (r_count != '0);
    assign o_full   = (r_count == CW'(DEPTH));
    assign o_rd_job = r_mem[r_rd_ptr];
    assign do_push  = i_push & ~o_full;
    assign do_pop   = i_pop & o_valid;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job pushed into a full queue");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue fill count lost a push");

endmodule

// File: rtl/core/bmp_back.sv
// Back end of the packet parser: takes jobs from the queue and sends their
// bytes out one per transaction from an output register. Depends on bmp_pkg.
module bmp_back
    import bmp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_first,
    output logic       o_last
);

    logic       r_valid;
    t_job       r_job;
    logic [1:0] r_idx;
    logic       at_end, done;

    assign at_end = (r_idx == r_job.cnt - 2'd1);
    assign done   = r_valid & i_ready & at_end;
    assign o_pop  = i_job_valid & (~r_valid | done);

    always_comb begin
        case (r_idx)
            2'd0:    o_byte = r_job.bytes[0];
            2'd1:    o_byte = r_job.bytes[1];
            default: o_byte = r_job.bytes[2];
        endcase
    end

    assign o_valid = r_valid;
    assign o_first = r_job.first & (r_idx == 2'd0);
    assign o_last  = r_job.last & at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (done) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (r_valid && i_ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_idx < r_job.cnt))
        else $error("byte index ran past the end of the job");

    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (!r_valid || (i_ready && at_end)))
        else $error("new job loaded over one still being sent");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_valid)
        else $error("output valid after reset");

endmodule

// File: rtl/core/ble_midi_packet_parser.sv
// Top level of the BLE MIDI packet parser: front end, job queue and back end.
// Depends on bmp_pkg, bmp_front, bmp_fifo and bmp_back.
//
// Usage:
//   The slave channel takes the raw bytes of BLE MIDI packets, one byte per
//   transaction, with s_axis_tlast high on the final byte of each packet.
//   The master channel delivers decoded MIDI message bytes, one per
//   transaction; tuser is high on the first byte of a message and tlast on
//   the byte that ends a message or a sysex run.
//   Header and timestamp bytes are dropped; complete channel and system
//   messages come out as a burst of one to three bytes, sysex streams
//   byte by byte. Messages cut short by the end of a packet are discarded.
// Timing:
//   One input byte is accepted per cycle while the job queue has room.
//   A message byte passes through the job queue and the back end's output
//   register. While tready is high, the master side sends one byte per
//   cycle, and the queue (QUEUE_DEPTH jobs) absorbs the bursts that
//   three-byte messages make.
// Reset and stalls:
//   Reset empties the queue and returns the parser to the packet header.
//   When the receiver holds tready low, the output register holds its byte,
//   the queue fills, and s_axis_tready drops only once the queue is full.
module ble_midi_packet_parser
    import bmp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Slave side: raw packet bytes.
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  logic       i_s_axis_tlast,   // packet_end
    // Master side: decoded message bytes.
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] msg_byte
    output logic       o_m_axis_tuser,   // [0] msg_first
    output logic       o_m_axis_tlast    // msg_last
);

    logic in_accept;
    logic push, pop, q_valid, q_full;
    t_job wr_job, rd_job;

    // The front end is never stalled by the back end directly; only a full
    // queue holds off new input bytes.
    assign o_s_axis_tready = ~q_full;
    assign in_accept       = i_s_axis_tvalid & ~q_full;

    bmp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_s_axis_tdata),
        .i_end    (i_s_axis_tlast),
        .o_push   (push),
        .o_job    (wr_job)
    );

    bmp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_wr_job (wr_job),
        .i_pop    (pop),
        .o_valid  (q_valid),
        .o_full   (q_full),
        .o_rd_job (rd_job)
    );

    bmp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (rd_job),
        .o_pop       (pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_byte      (o_m_axis_tdata),
        .o_first     (o_m_axis_tuser),
        .o_last      (o_m_axis_tlast)
    );

endmodule

// File: tb/sv/bmp_stream_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the BLE MIDI packet parser. It decodes every accepted raw byte
// on its own and compares each message byte that leaves the block, field by field.
// Depends on bmp_pkg for the MIDI status constants.
module bmp_stream_checker
    import bmp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_data,
    input  logic       i_in_last,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_data,
    input  logic       i_out_first,
    input  logic       i_out_last,
    output int         o_mismatch_count,
    output int         o_expected_left,
    output int         o_bytes_checked
);

    localparam int REPORT_LIMIT = 10;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_STAMP,
        PH_STATUS,
        PH_COLLECT,
        PH_SYSEX
    } t_phase;

    typedef struct packed {
        logic [7:0] value;
        logic       first;
        logic       last;
    } t_msg_byte;

    t_phase     phase;
    logic [7:0] held_status;
    logic [7:0] held_data;
    logic [1:0] data_left;
    t_msg_byte  expected_bytes[$];
    int         mismatches;
    int         checked;

    // Message length in bytes as given by the status byte; zero for data and F0.
    function automatic int unsigned message_length(input logic [7:0] st);
        logic [7:0] upper;
        upper = st & ST_HI_MASK;
        if ((st & ST_STATUS_BIT) == 8'h00) begin
            return 0;
        end
        if (upper != ST_HI_MASK) begin
            return (upper == ST_PROG_CHANGE || upper == ST_CHAN_PRESS) ? 2 : 3;
        end
        case (st)
            ST_SYSEX_START:              return 0;
            ST_MTC_QFRAME, ST_SONG_SEL:  return 2;
            ST_SONG_POS:                 return 3;
            default:                     return 1;
        endcase
    endfunction

    task automatic flag_mismatch(input string text);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("[%0t] mismatch %0d: %s", $realtime, mismatches, text);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic pkt_end);
        t_phase      next_phase;
        int unsigned len;
        next_phase = PH_STAMP;
        len = message_length(b);
        case (phase)
            PH_STAMP: begin
                next_phase = PH_STATUS;
            end
            PH_STATUS: begin
                if ((b & ST_STATUS_BIT) == 8'h00) begin
                    // A stray data byte: the byte after it is taken as a timestamp.
                    next_phase = PH_STAMP;
                end else if (b == ST_SYSEX_START) begin
                    expected_bytes.push_back({b, 1'b1, pkt_end});
                    next_phase = PH_SYSEX;
                end else if (len == 1) begin
                    expected_bytes.push_back({b, 1'b1, 1'b1});
                    next_phase = PH_STAMP;
                end else begin
                    held_status = b;
                    data_left = 2'(len - 1);
                    next_phase = PH_COLLECT;
                end
            end
            PH_COLLECT: begin
                if (data_left == 2'd2) begin
                    held_data = b;
                    data_left = 2'd1;
                    next_phase = PH_COLLECT;
                end else begin
                    expected_bytes.push_back({held_status, 1'b1, 1'b0});
                    if (message_length(held_status) == 3) begin
                        expected_bytes.push_back({held_data, 1'b0, 1'b0});
                    end
                    expected_bytes.push_back({b, 1'b0, 1'b1});
                    data_left = 2'd0;
                    next_phase = PH_STAMP;
                end
            end
            PH_SYSEX: begin
                if (b == ST_SYSEX_END) begin
                    expected_bytes.push_back({b, 1'b0, 1'b1});
                    next_phase = PH_STAMP;
                end else begin
                    expected_bytes.push_back({b, 1'b0, pkt_end});
                    next_phase = PH_SYSEX;
                end
            end
            default: begin
                next_phase = PH_STAMP;
            end
        endcase
        // The end of a packet drops whatever message is still being collected.
        if (pkt_end) begin
            next_phase = PH_HEADER;
            data_left = 2'd0;
        end
        phase = next_phase;
    endtask

    task automatic check_output();
        t_msg_byte want;
        if (expected_bytes.size() == 0) begin
            flag_mismatch($sformatf("unexpected byte %02h first=%b last=%b",
                                    i_out_data, i_out_first, i_out_last));
            return;
        end
        want = expected_bytes.pop_front();
        checked++;
        if (i_out_data !== want.value || i_out_first !== want.first
                || i_out_last !== want.last) begin
            flag_mismatch($sformatf("expected %02h first=%b last=%b, got %02h first=%b last=%b",
                                    want.value, want.first, want.last,
                                    i_out_data, i_out_first, i_out_last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase = PH_HEADER;
            held_status = 8'h00;
            held_data = 8'h00;
            data_left = 2'd0;
            expected_bytes.delete();
            mismatches = 0;
            checked = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_output();
            end
            if (i_in_valid && i_in_ready) begin
                decode_byte(i_in_data, i_in_last);
            end
        end
        o_expected_left <= expected_bytes.size();
        o_mismatch_count <= mismatches;
        o_bytes_checked <= checked;
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the BLE MIDI packet parser testbench: clock, reset, packet stimulus,
// receiver stalls and the verdict. Depends on bmp_pkg, the parser and bmp_stream_checker.
module tb_top;
    import bmp_pkg::*;

    localparam int RANDOM_ITEMS  = 280;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int HOLD_CYCLES   = 160;
    localparam int SETTLE_CYCLES = 8;

    // Status codes that the package does not name.
    localparam logic [7:0] NOTE_OFF     = 8'h80;
    localparam logic [7:0] NOTE_ON      = 8'h90;
    localparam logic [7:0] POLY_PRESS   = 8'hA0;
    localparam logic [7:0] CTRL_CHANGE  = 8'hB0;
    localparam logic [7:0] PITCH_BEND   = 8'hE0;
    localparam logic [7:0] SYS_UNDEF    = 8'hF4;
    localparam logic [7:0] ACTIVE_SENSE = 8'hFE;
    localparam logic [7:0] SYS_RESET    = 8'hFF;

    logic       clk     = 1'b0;
    logic       rst_n   = 1'b0;
    logic       s_valid = 1'b0;
    logic [7:0] s_data  = 8'h00;
    logic       s_last  = 1'b0;
    logic       m_ready = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_data;
    logic       m_user;
    logic       m_last;

    int mismatch_count;
    int expected_left;
    int bytes_checked;
    int cycle_count  = 0;
    int bytes_sent   = 0;
    int packets_sent = 0;
    int burst_left   = 0;
    int hold_ticket  = 0;
    bit gapless      = 1'b0;

    // Raw bytes of the packet being built; the last one goes out with tlast.
    logic [7:0] pkt[$];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ble_midi_packet_parser i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // [7:0] data_byte
        .i_s_axis_tlast  (s_last),   // packet_end
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),   // [7:0] msg_byte
        .o_m_axis_tuser  (m_user),   // [0] msg_first
        .o_m_axis_tlast  (m_last)    // msg_last
    );

    bmp_stream_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (s_valid),
        .i_in_ready       (s_ready),
        .i_in_data        (s_data),
        .i_in_last        (s_last),
        .i_out_valid      (m_valid),
        .i_out_ready      (m_ready),
        .i_out_data       (m_data),
        .i_out_first      (m_user),
        .i_out_last       (m_last),
        .o_mismatch_count (mismatch_count),
        .o_expected_left  (expected_left),
        .o_bytes_checked  (bytes_checked)
    );

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offers one raw byte and waits for its transaction. The sender works in
    // bursts; between bursts it may drop tvalid. While gapless
    // is set, the bytes go out back to back.
    task automatic send_byte(input logic [7:0] b, input logic pkt_end);
        int gap;
        if (burst_left == 0 && !gapless) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_valid <= 1'b1;
        s_data <= b;
        s_last <= pkt_end;
        do @(posedge clk); while (!(s_valid && s_ready));
        bytes_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt.size(); i++) begin
            send_byte(pkt[i], i == pkt.size() - 1);
        end
        packets_sent++;
    endtask

    // Stops offering bytes until every predicted message byte has arrived, then
    // lets bytes that release nothing but are still in flight settle.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge clk); while (expected_left != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic add_stamp();
        pkt.push_back({1'b1, 7'($urandom_range(0, 127))});
    endtask

    // Data bytes are normally below 80h, but the parser does not check them.
    task automatic add_data();
        if ($urandom_range(0, 7) == 0) begin
            pkt.push_back(8'($urandom_range(0, 255)));
        end else begin
            pkt.push_back({1'b0, 7'($urandom_range(0, 127))});
        end
    endtask

    // Appends one message. A sysex run may be left open when it is the final
    // message of the packet, so that the packet end closes it.
    task automatic add_message(input bit may_cut, output bit cut);
        int         kind;
        int         sysex_len;
        logic [7:0] upper;
        cut = 1'b0;
        kind = $urandom_range(0, 11);
        upper = NOTE_OFF;
        case (kind)
            0, 1, 2, 3, 4: begin
                case (kind)
                    0:       upper = NOTE_OFF;
                    1:       upper = NOTE_ON;
                    2:       upper = POLY_PRESS;
                    3:       upper = CTRL_CHANGE;
                    default: upper = PITCH_BEND;
                endcase
                pkt.push_back(upper | 8'($urandom_range(0, 15)));
                add_data();
                add_data();
            end
            5: begin
                upper = ($urandom_range(0, 1) == 1) ? ST_PROG_CHANGE : ST_CHAN_PRESS;
                pkt.push_back(upper | 8'($urandom_range(0, 15)));
                add_data();
            end
            6: begin
                pkt.push_back(($urandom_range(0, 1) == 1) ? ST_MTC_QFRAME : ST_SONG_SEL);
                add_data();
            end
            7: begin
                pkt.push_back(ST_SONG_POS);
                add_data();
                add_data();
            end
            8: begin
                // Realtime and undefined system codes, and a lone sysex end.
                pkt.push_back(8'($urandom_range(SYS_UNDEF, SYS_RESET)));
            end
            9, 10: begin
                pkt.push_back(ST_SYSEX_START);
                sysex_len = $urandom_range(0, 6);
                repeat (sysex_len) add_data();
                if (may_cut && $urandom_range(0, 3) == 0) begin
                    cut = 1'b1;
                end else begin
                    pkt.push_back(ST_SYSEX_END);
                end
            end
            default: begin
                // A data byte where a status belongs, followed by any byte.
                pkt.push_back({1'b0, 7'($urandom_range(0, 127))});
                pkt.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // Header, first timestamp, then messages each led by a timestamp.
    task automatic build_packet(input int n_msgs);
        bit cut;
        pkt.delete();
        pkt.push_back(8'($urandom_range(0, 255)));
        add_stamp();
        for (int i = 0; i < n_msgs; i++) begin
            if (i > 0) begin
                add_stamp();
            end
            add_message(i == n_msgs - 1, cut);
            if (cut) begin
                break;
            end
        end
    endtask

    // Receiver: each stretch picks a stall pattern of its own. When the
    // stimulus raises hold_ticket, tready stays low long enough that
    // the parser's queue fills and its input stalls.
    initial begin : receiver
        int mode;
        int span;
        int served;
        int tick;
        served = 0;
        tick = 0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 96);
            repeat (span) begin
                @(posedge clk);
                tick++;
                if (hold_ticket != served) begin
                    served = hold_ticket;
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 1) == 1);
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        int sel;
        int random_start;
        int drop;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed packets. A one-byte and a two-byte packet release nothing.
        pkt = '{8'h80};
        send_packet();
        pkt = '{8'hBF, 8'h80};
        send_packet();
        // Messages of each size, with extreme data values.
        pkt = '{8'h80, 8'h80, NOTE_ON, 8'h00, 8'h7F, 8'h81, ST_PROG_CHANGE | 8'h03, 8'h55,
                8'h82, ST_SONG_POS, 8'h01, 8'h02, 8'h83, ACTIVE_SENSE};
        send_packet();
        // A stray data byte that swallows the next one, a closed sysex run, and
        // a sysex start that is also the last byte of the packet.
        pkt = '{8'h80, 8'h80, 8'h45, 8'h12, ST_SYSEX_START, 8'h7E, ST_SYSEX_END, 8'h84,
                ST_SYSEX_START};
        send_packet();
        // A pitch bend cut short by the packet end is dropped.
        pkt = '{8'h80, 8'h80, PITCH_BEND, 8'h7F};
        send_packet();
        wait_for_results();

        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_ITEMS) begin
            if (packets_sent == 12 || packets_sent == 45) begin
                wait_for_results();
            end
            if (packets_sent == 25) begin
                // Long receiver hold while a long sysex run goes in back to back.
                hold_ticket <= hold_ticket + 1;
                gapless = 1'b1;
                pkt.delete();
                pkt.push_back(8'h80);
                add_stamp();
                pkt.push_back(ST_SYSEX_START);
                repeat (40) add_data();
                pkt.push_back(ST_SYSEX_END);
                send_packet();
                gapless = 1'b0;
            end
            sel = $urandom_range(0, 9);
            case (sel)
                0: begin
                    pkt.delete();
                    repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom_range(0, 255)));
                end
                1: begin
                    pkt.delete();
                    repeat ($urandom_range(1, 2)) pkt.push_back(8'($urandom_range(0, 255)));
                end
                2: begin
                    // Well formed, then cut short, which may leave the last message incomplete.
                    build_packet($urandom_range(1, 3));
                    drop = $urandom_range(1, 2);
                    if (pkt.size() > 3) begin
                        repeat (drop) void'(pkt.pop_back());
                    end
                end
                default: begin
                    build_packet($urandom_range(1, 4));
                end
            endcase
            send_packet();
        end

        wait_for_results();
        $display("Sent %0d packets with %0d raw bytes, including a long output stall.",
                 packets_sent, bytes_sent);
        $display("Checked %0d message bytes; %0d mismatches, %0d still expected.",
                 bytes_checked, mismatch_count, expected_left);
        if (mismatch_count == 0 && expected_left == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: ble_midi_packet_parser.f
rtl/core/bmp_pkg.sv
rtl/core/bmp_front.sv
rtl/core/bmp_fifo.sv
rtl/core/bmp_back.sv
rtl/core/ble_midi_packet_parser.sv
tb/sv/bmp_stream_checker.sv
tb/sv/tb_top.sv
